/* sv/fqmr_pkg.sv */
package fqmr_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_BITS    = 32;
	localparam int COUNT_BITS    = 5;

	localparam logic [2:0] OP_ENQ  = 3'd0;
	localparam logic [2:0] OP_DEQ  = 3'd1;
	localparam logic [2:0] OP_PEEK = 3'd2;
	localparam logic [2:0] OP_FIND = 3'd3;
	localparam logic [2:0] OP_REMF = 3'd4;
	localparam logic [2:0] OP_REMA = 3'd5;

	localparam logic [1:0] STS_OK    = 2'd0;
	localparam logic [1:0] STS_FULL  = 2'd1;
	localparam logic [1:0] STS_EMPTY = 2'd2;

	typedef struct packed {
		logic [2:0]            op;
		logic [VALUE_BITS-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] item_out;
		logic                  found;
		logic [1:0]            status;
		logic [COUNT_BITS-1:0] removed_count;
		logic [COUNT_BITS-1:0] occupancy;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic start;
		logic rd;
		logic emit;
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_need;
		logic last_rd;
		logic out_free;
	} sts_t;

endpackage

/* sv/fqmr_ram.sv */
module fqmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* sv/fqmr_ctrl.sv */
module fqmr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  fqmr_pkg::sts_t sts,
	output fqmr_pkg::ctl_t ctl
);

	import fqmr_pkg::*;

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_EMIT  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		state_d   = state_q;
		ctl.start = 1'b0;
		ctl.rd    = 1'b0;
		ctl.emit  = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					ctl.start = 1'b1;
					state_d   = sts.scan_need ? S_READ : S_EMIT;
				end
			end
			S_READ: begin
				ctl.rd = 1'b1;
				if (sts.last_rd) begin
					state_d = S_DRAIN;
				end
			end
			// last read word is folded in during this cycle
			S_DRAIN: begin
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					ctl.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* sv/fqmr_dp.sv */
module fqmr_dp #(
	parameter int DEPTH     = fqmr_pkg::DEPTH_DEF,
	parameter int WORD_BITS = fqmr_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  fqmr_pkg::cmd_t cmd_data,
	input  logic           rsp_stall,
	output logic           rsp_valid,
	output fqmr_pkg::rsp_t rsp_data,
	input  fqmr_pkg::ctl_t ctl,
	output fqmr_pkg::sts_t sts
);

	import fqmr_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [SW-1:0] s;
		s = SW'(base) + SW'(off);
		if (s >= SW'(DEPTH)) begin
			s = s - SW'(DEPTH);
		end
		return AW'(s);
	endfunction

	logic [AW-1:0]        head_q;
	logic [CW-1:0]        count_q;
	logic [2:0]           op_q;
	logic [WORD_BITS-1:0] val_q;
	logic [CW-1:0]        len_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        keep_q;
	logic [CW-1:0]        removed_q;
	logic [WORD_BITS-1:0] item_q;
	logic                 found_q;
	logic                 enq_ok_q;
	logic                 rd_vld_s1;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	logic [WORD_BITS-1:0] val_w;
	logic                 enq_ok;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [WORD_BITS-1:0] wdata;
	logic [AW-1:0]        raddr;
	logic [WORD_BITS-1:0] rdata;
	logic                 match;
	logic                 take;
	logic                 drop;
	logic                 keep_wr;
	logic [CW-1:0]        cnt_new;
	logic [1:0]           status_new;

	assign val_w  = WORD_BITS'(cmd_data.value);
	assign enq_ok = (cmd_data.op == OP_ENQ) && (count_q < CW'(DEPTH));

	assign sts.scan_need = (count_q != '0) && (cmd_data.op inside
		{OP_DEQ, OP_PEEK, OP_FIND, OP_REMF, OP_REMA});
	assign sts.last_rd   = ((idx_q + CW'(1)) == len_q);
	assign sts.out_free  = !rsp_valid_q || !rsp_stall;

	// fold in one read word per cycle
	always_comb begin
		match   = (rdata == val_q);
		take    = 1'b0;
		drop    = 1'b0;
		keep_wr = 1'b0;
		case (op_q)
			OP_DEQ, OP_PEEK: begin
				take = 1'b1;
			end
			OP_FIND: begin
				take = match && !found_q;
			end
			OP_REMF: begin
				take    = match && !found_q;
				drop    = take;
				keep_wr = !drop;
			end
			OP_REMA: begin
				drop    = match;
				keep_wr = !drop;
			end
			default: begin
				take = 1'b0;
			end
		endcase
	end

	assign we    = (ctl.start && enq_ok) || (rd_vld_s1 && keep_wr);
	assign waddr = wrap_add(head_q, ctl.start ? count_q : keep_q);
	assign wdata = ctl.start ? val_w : rdata;
	assign raddr = wrap_add(head_q, idx_q);

	fqmr_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign cnt_new = count_q + CW'(enq_ok_q) - removed_q;

	always_comb begin
		case (op_q)
			OP_ENQ:  status_new = enq_ok_q ? STS_OK : STS_FULL;
			OP_DEQ, OP_PEEK, OP_FIND, OP_REMF, OP_REMA:
				status_new = found_q ? STS_OK : STS_EMPTY;
			default: status_new = STS_OK;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q      <= cmd_data.op;
			val_q     <= val_w;
			enq_ok_q  <= enq_ok;
			len_q     <= (cmd_data.op inside {OP_DEQ, OP_PEEK}) ? CW'(1) : count_q;
			idx_q     <= '0;
			keep_q    <= '0;
			removed_q <= '0;
			item_q    <= '0;
			found_q   <= 1'b0;
		end else begin
			if (ctl.rd) begin
				idx_q <= idx_q + CW'(1);
			end
			if (rd_vld_s1) begin
				if (take) begin
					item_q <= rdata;
				end
				if (take || drop) begin
					found_q <= 1'b1;
				end
				if (op_q == OP_DEQ) begin
					removed_q <= CW'(1);
				end else if (drop) begin
					removed_q <= removed_q + CW'(1);
				end
				if (keep_wr) begin
					keep_q <= keep_q + CW'(1);
				end
			end
		end
		if (ctl.emit) begin
			rsp_q.item_out      <= (op_q == OP_REMA) ? '0 : VALUE_BITS'(item_q);
			rsp_q.found         <= found_q;
			rsp_q.status        <= status_new;
			rsp_q.removed_count <= COUNT_BITS'(removed_q);
			rsp_q.occupancy     <= COUNT_BITS'(cnt_new);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			rd_vld_s1   <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= ctl.rd;
			if (ctl.emit) begin
				count_q <= cnt_new;
				if ((op_q == OP_DEQ) && found_q) begin
					head_q <= wrap_add(head_q, CW'(1));
				end
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

endmodule

/* sv/fifo_queue_with_match_removal.sv */
// channel   dir  payload    handshake
// cmd       in   cmd_data   cmd_valid / cmd_stall
// rsp       out  rsp_data   rsp_valid / rsp_stall
//
// one command at a time; enqueue, refused or empty-queue commands and unused codes
// go from transfer straight to the result; dequeue and peek first read one entry
// find and remove commands read every occupied entry: the single ram read port
// visits one entry per cycle while compaction writes behind it
// arst_n clears occupancy and head pointer; entry storage is not cleared
// a held result stalls completion of the next command, not its transfer
module fifo_queue_with_match_removal #(
	parameter int DEPTH     = fqmr_pkg::DEPTH_DEF,
	parameter int WORD_BITS = fqmr_pkg::WORD_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  fqmr_pkg::cmd_t cmd_data,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output fqmr_pkg::rsp_t rsp_data
);

	import fqmr_pkg::*;

	ctl_t ctl;
	sts_t sts;

	fqmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	fqmr_dp #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_data  (cmd_data),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data),
		.ctl       (ctl),
		.sts       (sts)
	);

endmodule

/* sv/fqmr_chk.sv */
module fqmr_chk #(
	parameter int DEPTH = fqmr_pkg::DEPTH_DEF
) (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_stall,
	input fqmr_pkg::cmd_t cmd_data,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input fqmr_pkg::rsp_t rsp_data
);

	import fqmr_pkg::*;

	// held result stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// one command in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while another is in progress");

	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (DEPTH > 31) || (rsp_data.occupancy <= DEPTH))
		else $error("occupancy beyond depth");

	a_full_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.status == STS_FULL) |->
			!rsp_data.found && (rsp_data.removed_count == '0))
		else $error("refused enqueue reports a word");

	a_removed_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_data.removed_count != '0) |->
			rsp_data.found && (rsp_data.status == STS_OK))
		else $error("removal without a match");

endmodule

bind fifo_queue_with_match_removal fqmr_chk #(.DEPTH(DEPTH)) u_chk (.*);
